// ===== src/apu_pkg.sv =====
// Shared types and constants for the Adam parameter update core.
package apu_pkg;

  typedef enum logic [1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_BETA_FIRST    = 2'd1,
    CFG_BETA_SECOND   = 2'd2,
    CFG_SAMPLE_COUNT  = 2'd3
  } cfg_index_t;

  localparam logic [15:0] LEARNING_RATE_RST = 16'd66;
  localparam logic [15:0] BETA_FIRST_RST    = 16'd58982;
  localparam logic [15:0] BETA_SECOND_RST   = 16'd65470;
  localparam logic [20:0] SAMPLE_COUNT_RST  = 21'd1000;
  localparam logic [15:0] BETA_POWER_ONE    = 16'hFFFF;
  localparam logic [16:0] Q16_ONE           = 17'h10000;

endpackage

// ===== src/adam_parameter_update_core.sv =====
// Adam optimizer update core: per-parameter moment memories and a streaming pipeline.
//
// One parameter update enters and one result leaves per cycle unless the skid
// register is full or the clearing pass runs. The pipeline holds three input stages,
// a 48-stage gradient divider, three stages around the moment memories, a 64-stage
// bias-correction divider, a 32-stage square root, one product stage, a 64-stage step
// divider and the output register. The first and second moments sit in two
// single-port-write memories read one stage ahead of the update; a same-address write
// issued with the read is forwarded. After reset, with in_tready low, a clearing pass
// zeroes both memories, one entry per cycle, over all VISIBLE_COUNT + HIDDEN_COUNT +
// VISIBLE_COUNT*HIDDEN_COUNT entries (288 at default parameters). The beta powers
// advance on a transfer with pass_start set, before that item is computed.
// Configuration writes are taken at any time but are meant for an idle block.
module adam_parameter_update_core #(
  parameter int VISIBLE_COUNT = 16,
  parameter int HIDDEN_COUNT  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [8:0] param_address, [40:9] weighted_sum, [72:41] plain_sum,
  // [104:73] energy_mean, [111:105] zero
  input  logic [111:0] in_tdata,
  // [0] pass_start
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] update_step, [40:32] out_address, [47:41] zero
  output logic [47:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [20:0]  cfg_data
);

  localparam int PARAM_TOTAL = VISIBLE_COUNT + HIDDEN_COUNT + VISIBLE_COUNT * HIDDEN_COUNT;
  localparam int IDX_W       = $clog2(PARAM_TOTAL);

  // configuration
  logic [15:0] learning_rate_r;
  logic [15:0] beta_first_r;
  logic [15:0] beta_second_r;
  logic [20:0] sample_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r <= apu_pkg::LEARNING_RATE_RST;
      beta_first_r    <= apu_pkg::BETA_FIRST_RST;
      beta_second_r   <= apu_pkg::BETA_SECOND_RST;
      sample_count_r  <= apu_pkg::SAMPLE_COUNT_RST;
    end else if (cfg_valid) begin
      case (apu_pkg::cfg_index_t'(cfg_index))
        apu_pkg::CFG_LEARNING_RATE: learning_rate_r <= cfg_data[15:0];
        apu_pkg::CFG_BETA_FIRST:    beta_first_r    <= cfg_data[15:0];
        apu_pkg::CFG_BETA_SECOND:   beta_second_r   <= cfg_data[15:0];
        apu_pkg::CFG_SAMPLE_COUNT:  sample_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline enable and clearing pass
  logic             en;
  logic             skid_valid_r;
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic             accept;

  assign en        = !skid_valid_r;
  assign in_tready = en && !clr_busy_r;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(PARAM_TOTAL - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // beta powers
  logic [15:0] pow1_r;
  logic [15:0] pow2_r;
  logic [32:0] pow1_prod;
  logic [32:0] pow2_prod;
  logic [15:0] pow1_sel;
  logic [15:0] pow2_sel;

  assign pow1_prod = ({16'b0, pow1_r} + 33'd1) * {17'b0, beta_first_r};
  assign pow2_prod = ({16'b0, pow2_r} + 33'd1) * {17'b0, beta_second_r};
  assign pow1_sel  = in_tuser ? pow1_prod[31:16] : pow1_r;
  assign pow2_sel  = in_tuser ? pow2_prod[31:16] : pow2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow1_r <= apu_pkg::BETA_POWER_ONE;
      pow2_r <= apu_pkg::BETA_POWER_ONE;
    end else if (accept && in_tuser) begin
      pow1_r <= pow1_sel;
      pow2_r <= pow2_sel;
    end
  end

  // stage 0: input register
  logic               s0_valid_r;
  logic [8:0]         s0_addr_r;
  logic               s0_inrange_r;
  logic signed [31:0] s0_w_r;
  logic signed [31:0] s0_p_r;
  logic signed [31:0] s0_mean_r;
  logic [16:0]        s0_d1_r;
  logic [16:0]        s0_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_addr_r    <= in_tdata[8:0];
      s0_inrange_r <= (32'(in_tdata[8:0]) < 32'(PARAM_TOTAL));
      s0_w_r       <= in_tdata[40:9];
      s0_p_r       <= in_tdata[72:41];
      s0_mean_r    <= in_tdata[104:73];
      s0_d1_r      <= apu_pkg::Q16_ONE - {1'b0, pow1_sel};
      s0_d2_r      <= apu_pkg::Q16_ONE - {1'b0, pow2_sel};
    end
  end

  // stage 1: mean * plain
  logic               s1_valid_r;
  logic [8:0]         s1_addr_r;
  logic               s1_inrange_r;
  logic signed [31:0] s1_w_r;
  logic signed [63:0] s1_pw_r;
  logic [16:0]        s1_d1_r;
  logic [16:0]        s1_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_addr_r    <= s0_addr_r;
      s1_inrange_r <= s0_inrange_r;
      s1_w_r       <= s0_w_r;
      s1_pw_r      <= 64'(s0_mean_r) * 64'(s0_p_r);
      s1_d1_r      <= s0_d1_r;
      s1_d2_r      <= s0_d2_r;
    end
  end

  // stage 2: difference magnitude, divisor
  logic signed [63:0] s1_diff;
  logic               s1_neg;
  logic [63:0]        s1_mag;

  assign s1_diff = {{16{s1_w_r[31]}}, s1_w_r, 16'h0000} - s1_pw_r;
  assign s1_neg  = s1_diff[63];
  assign s1_mag  = s1_neg ? (64'd0 - s1_diff) : s1_diff;

  logic        s2_valid_r;
  logic [47:0] s2_num_r;
  logic [20:0] s2_den_r;
  logic [44:0] s2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // divide by samples * 2^15: drop 15 bits, then divide by samples
      s2_num_r <= s1_mag[62:15];
      s2_den_r <= (sample_count_r == 21'd0) ? 21'd1 : sample_count_r;
      s2_sb_r  <= {s1_addr_r, s1_inrange_r, s1_neg, s1_d1_r, s1_d2_r};
    end
  end

  logic        gd_valid;
  logic [47:0] gd_quo;
  logic [44:0] gd_sb;

  apu_div #(.N(48), .D(21), .SB_W(45)) u_grad_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_valid_r),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_sb     (s2_sb_r),
    .out_valid (gd_valid),
    .out_quo   (gd_quo),
    .out_sb    (gd_sb)
  );

  // stage 3: saturated gradient
  logic        gd_neg;
  logic [31:0] g_c;
  logic [31:0] gmag_c;

  assign gd_neg = gd_sb[34];

  always_comb begin
    if (gd_neg) begin
      if (gd_quo > 48'h0000_8000_0000) begin
        g_c    = 32'h8000_0000;
        gmag_c = 32'h8000_0000;
      end else begin
        g_c    = 32'd0 - gd_quo[31:0];
        gmag_c = gd_quo[31:0];
      end
    end else begin
      if (gd_quo > 48'h0000_7FFF_FFFF) begin
        g_c    = 32'h7FFF_FFFF;
        gmag_c = 32'h7FFF_FFFF;
      end else begin
        g_c    = gd_quo[31:0];
        gmag_c = gd_quo[31:0];
      end
    end
  end

  logic               s3_valid_r;
  logic [8:0]         s3_addr_r;
  logic               s3_inrange_r;
  logic signed [31:0] s3_g_r;
  logic [31:0]        s3_gmag_r;
  logic [16:0]        s3_d1_r;
  logic [16:0]        s3_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= gd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_addr_r    <= gd_sb[44:36];
      s3_inrange_r <= gd_sb[35];
      s3_g_r       <= g_c;
      s3_gmag_r    <= gmag_c;
      s3_d1_r      <= gd_sb[33:17];
      s3_d2_r      <= gd_sb[16:0];
    end
  end

  // stage 4: squared gradient, moment read
  logic [63:0] s3_gsq;
  assign s3_gsq = 64'(s3_gmag_r) * 64'(s3_gmag_r);

  logic               s4_valid_r;
  logic [8:0]         s4_addr_r;
  logic               s4_inrange_r;
  logic signed [31:0] s4_g_r;
  logic [47:0]        s4_gsq_r;
  logic [16:0]        s4_d1_r;
  logic [16:0]        s4_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_addr_r    <= s3_addr_r;
      s4_inrange_r <= s3_inrange_r;
      s4_g_r       <= s3_g_r;
      s4_gsq_r     <= (s3_gsq[63:48] != 16'd0) ? 48'hFFFF_FFFF_FFFF : s3_gsq[47:0];
      s4_d1_r      <= s3_d1_r;
      s4_d2_r      <= s3_d2_r;
    end
  end

  // moment memories
  logic [31:0]      m_mem [PARAM_TOTAL];
  logic [47:0]      v_mem [PARAM_TOTAL];
  logic [31:0]      m_rd_r;
  logic [47:0]      v_rd_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      m_wdata;
  logic [47:0]      v_wdata;
  logic [31:0]      m_new;
  logic [47:0]      v_new;

  always_ff @(posedge clk) begin
    if (en) begin
      m_rd_r <= m_mem[IDX_W'(s3_addr_r)];
      v_rd_r <= v_mem[IDX_W'(s3_addr_r)];
    end
  end

  assign wr_en   = clr_busy_r || (en && s4_valid_r && s4_inrange_r);
  assign wr_idx  = clr_busy_r ? clr_idx_r : IDX_W'(s4_addr_r);
  assign m_wdata = clr_busy_r ? 32'd0 : m_new;
  assign v_wdata = clr_busy_r ? 48'd0 : v_new;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      m_mem[wr_idx] <= m_wdata;
      v_mem[wr_idx] <= v_wdata;
    end
  end

  // moment update, forwarding the write made as this item's read was issued
  logic               s5_valid_r;
  logic [8:0]         s5_addr_r;
  logic               s5_inrange_r;
  logic signed [31:0] s5_m_r;
  logic [47:0]        s5_v_r;
  logic [16:0]        s5_d1_r;
  logic [16:0]        s5_d2_r;

  logic               fwd;
  logic signed [31:0] m_old;
  logic [47:0]        v_old;
  logic signed [16:0] b1s;
  logic signed [17:0] c1s;
  logic [16:0]        c2;
  logic signed [49:0] m_acc;
  logic [63:0]        v_acc;

  assign fwd   = s5_valid_r && s5_inrange_r && (s5_addr_r == s4_addr_r);
  assign m_old = fwd ? s5_m_r : m_rd_r;
  assign v_old = fwd ? s5_v_r : v_rd_r;
  assign b1s   = {1'b0, beta_first_r};
  assign c1s   = {1'b0, apu_pkg::Q16_ONE - {1'b0, beta_first_r}};
  assign c2    = apu_pkg::Q16_ONE - {1'b0, beta_second_r};
  assign m_acc = 50'(b1s) * 50'(m_old) + 50'(c1s) * 50'(s4_g_r);
  assign v_acc = 64'(beta_second_r) * 64'(v_old) + 64'(c2) * 64'(s4_gsq_r);
  assign m_new = m_acc[47:16];
  assign v_new = v_acc[63:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_addr_r    <= s4_addr_r;
      s5_inrange_r <= s4_inrange_r;
      s5_m_r       <= m_new;
      s5_v_r       <= v_new;
      s5_d1_r      <= s4_d1_r;
      s5_d2_r      <= s4_d2_r;
    end
  end

  // bias correction
  logic        s5_neg;
  logic [31:0] s5_mabs;

  assign s5_neg  = s5_m_r[31];
  assign s5_mabs = s5_neg ? (32'd0 - s5_m_r) : s5_m_r;

  logic        md_valid;
  logic [63:0] md_quo;
  logic [9:0]  md_sb;
  logic        vd_valid;
  logic [63:0] vd_quo;
  logic        vd_sb;

  apu_div #(.N(64), .D(17), .SB_W(10)) u_mhat_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_valid_r),
    .in_num    ({16'h0000, s5_mabs, 16'h0000}),
    .in_den    (s5_d1_r),
    .in_sb     ({s5_addr_r, s5_neg}),
    .out_valid (md_valid),
    .out_quo   (md_quo),
    .out_sb    (md_sb)
  );

  apu_div #(.N(64), .D(17), .SB_W(1)) u_vhat_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_valid_r),
    .in_num    ({s5_v_r, 16'h0000}),
    .in_den    (s5_d2_r),
    .in_sb     (s5_inrange_r),
    .out_valid (vd_valid),
    .out_quo   (vd_quo),
    .out_sb    (vd_sb)
  );

  // root of corrected second moment; sideband {mhat, addr, neg, inrange}
  logic        sq_valid;
  logic [31:0] sq_root;
  logic [58:0] sq_sb;

  apu_sqrt #(.SB_W(59)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (md_valid && vd_valid),
    .in_x      (vd_quo),
    .in_sb     ({md_quo[47:0], md_sb, vd_sb}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // stage 6: eta * m_hat
  logic        s6_valid_r;
  logic [63:0] s6_prod_r;
  logic [31:0] s6_root_r;
  logic [10:0] s6_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_prod_r <= 64'(learning_rate_r) * 64'(sq_sb[58:11]);
      s6_root_r <= sq_root;
      // {addr, neg, forced zero}
      s6_sb_r   <= {sq_sb[10:2], sq_sb[1], (sq_root == 32'd0) || !sq_sb[0]};
    end
  end

  logic        sd_valid;
  logic [63:0] sd_quo;
  logic [10:0] sd_sb;

  apu_div #(.N(64), .D(32), .SB_W(11)) u_step_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s6_valid_r),
    .in_num    (s6_prod_r),
    .in_den    (s6_root_r),
    .in_sb     (s6_sb_r),
    .out_valid (sd_valid),
    .out_quo   (sd_quo),
    .out_sb    (sd_sb)
  );

  // saturate and sign the step
  logic [31:0] step_c;
  logic [40:0] res_c;

  always_comb begin
    if (sd_sb[0]) begin
      step_c = 32'd0;
    end else if (sd_sb[1]) begin
      step_c = (sd_quo > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - sd_quo[31:0]);
    end else begin
      step_c = (sd_quo > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : sd_quo[31:0];
    end
  end

  assign res_c = {sd_sb[10:2], step_c};

  // output register with skid stage
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [40:0] out_data_r;
  logic [40:0] out_data_nxt;
  logic        skid_valid_nxt;
  logic [40:0] skid_data_r;
  logic [40:0] skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (sd_valid) begin
      if (!out_valid_r || out_tready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_c;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_c;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, out_data_r};

endmodule

// ===== src/apu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module apu_div #(
  parameter int N    = 48,
  parameter int D    = 21,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [N-1:0]    in_num,
  input  logic [D-1:0]    in_den,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [N-1:0]    out_quo,
  output logic [SB_W-1:0] out_sb
);

  logic            valid_r [N];
  logic [N-1:0]    num_r   [N];
  logic [D-1:0]    rem_r   [N];
  logic [D-1:0]    den_r   [N];
  logic [SB_W-1:0] sb_r    [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic            valid_i;
    logic [N-1:0]    num_i;
    logic [D-1:0]    rem_i;
    logic [D-1:0]    den_i;
    logic [SB_W-1:0] sb_i;
    logic [D:0]      trial;
    logic [D:0]      diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign valid_i = in_valid;
      assign num_i   = in_num;
      assign rem_i   = '0;
      assign den_i   = in_den;
      assign sb_i    = in_sb;
    end else begin : g_next
      assign valid_i = valid_r[k-1];
      assign num_i   = num_r[k-1];
      assign rem_i   = rem_r[k-1];
      assign den_i   = den_r[k-1];
      assign sb_i    = sb_r[k-1];
    end

    assign trial = {rem_i, num_i[N-1]};
    assign ge    = (trial >= {1'b0, den_i});
    assign diff  = trial - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_i[N-2:0], ge};
        rem_r[k] <= ge ? diff[D-1:0] : trial[D-1:0];
        den_r[k] <= den_i;
        sb_r[k]  <= sb_i;
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_quo   = num_r[N-1];
  assign out_sb    = sb_r[N-1];

endmodule

// ===== src/apu_sqrt.sv =====
// Pipelined 64-bit integer square root, one root bit per stage, with sideband.
module apu_sqrt #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     in_x,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output logic [SB_W-1:0] out_sb
);

  localparam int STAGES = 32;

  logic            valid_r [STAGES];
  logic [63:0]     x_r     [STAGES];
  logic [33:0]     rem_r   [STAGES];
  logic [31:0]     root_r  [STAGES];
  logic [SB_W-1:0] sb_r    [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic            valid_i;
    logic [63:0]     x_i;
    logic [33:0]     rem_i;
    logic [31:0]     root_i;
    logic [SB_W-1:0] sb_i;
    logic [35:0]     trial;
    logic [35:0]     test;
    logic [35:0]     diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign valid_i = in_valid;
      assign x_i     = in_x;
      assign rem_i   = '0;
      assign root_i  = '0;
      assign sb_i    = in_sb;
    end else begin : g_next
      assign valid_i = valid_r[k-1];
      assign x_i     = x_r[k-1];
      assign rem_i   = rem_r[k-1];
      assign root_i  = root_r[k-1];
      assign sb_i    = sb_r[k-1];
    end

    assign trial = {rem_i, x_i[63:62]};
    assign test  = {2'b00, root_i, 2'b01};
    assign ge    = (trial >= test);
    assign diff  = trial - test;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= {x_i[61:0], 2'b00};
        rem_r[k]  <= ge ? diff[33:0] : trial[33:0];
        root_r[k] <= {root_i[30:0], ge};
        sb_r[k]   <= sb_i;
      end
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_root  = root_r[STAGES-1];
  assign out_sb    = sb_r[STAGES-1];

endmodule
